>>> hdl/atp_pkg.sv
`timescale 1ns / 1ps
package atp_pkg;

   typedef logic signed [31:0] q_type;

   localparam q_type Q_ONE       = 32'sd65536;
   localparam q_type Q_HALF      = 32'sd32768;
   localparam q_type Q_PI_HALF   = 32'sd102944;
   localparam q_type Q_ATAN_HALF = 32'sd30386;
   localparam q_type C_THIRD     = 32'sd21845;
   localparam q_type C_FIFTH     = 32'sd13107;
   localparam q_type C_SEVENTH   = 32'sd9362;

   // q16.16 product, floor shift by 16, wrapped to 32 bits
   function automatic q_type qmul(input q_type a, input q_type b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b);
      return p[47:16];
   endfunction

endpackage

>>> hdl/atp_recip.sv
`timescale 1ns / 1ps
module atp_recip #(
   parameter int SIDE_W = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  atp_pkg::q_type      in_value,
   input  logic [SIDE_W-1:0]   in_side,
   output logic                out_valid,
   output atp_pkg::q_type      out_value,
   output logic [SIDE_W-1:0]   out_side
);
   import atp_pkg::*;

   localparam int NST = 7;

   logic              v_ff    [NST];
   q_type             a_ff    [NST];
   q_type             est_ff  [NST];
   q_type             corr_ff [NST];
   logic              z_ff    [NST];
   logic [SIDE_W-1:0] side_ff [NST];
   q_type             est_in  [NST];
   q_type             corr_in [NST];

   // power-of-two seed from the leading one
   function automatic q_type seed_of(input q_type a);
      q_type s;
      s = '0;
      for (int i = 0; i < 32; i++) begin
         if (a[i]) begin
            s = q_type'(33'd1 << (31 - i));
         end
      end
      return s;
   endfunction

   assign est_in[0]  = seed_of(in_value);
   assign corr_in[0] = '0;

   // newton steps: odd stage forms the correction, even stage applies it
   for (genvar g = 1; g < NST; g++) begin : g_step
      if (g % 2 == 1) begin : g_corr
         assign corr_in[g] = Q_ONE - qmul(a_ff[g-1], est_ff[g-1]);
         assign est_in[g]  = est_ff[g-1];
      end else begin : g_upd
         assign corr_in[g] = corr_ff[g-1];
         assign est_in[g]  = est_ff[g-1] + qmul(est_ff[g-1], corr_ff[g-1]);
      end
   end

   // stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NST; s++) v_ff[s] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
         for (int s = 1; s < NST; s++) v_ff[s] <= v_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff[0]    <= in_value;
         z_ff[0]    <= (in_value <= 0);
         side_ff[0] <= in_side;
         for (int s = 1; s < NST; s++) begin
            a_ff[s]    <= a_ff[s-1];
            z_ff[s]    <= z_ff[s-1];
            side_ff[s] <= side_ff[s-1];
         end
         for (int s = 0; s < NST; s++) begin
            est_ff[s]  <= est_in[s];
            corr_ff[s] <= corr_in[s];
         end
      end
   end

   assign out_valid = v_ff[NST-1];
   assign out_value = z_ff[NST-1] ? '0 : est_ff[NST-1];
   assign out_side  = side_ff[NST-1];

endmodule

>>> hdl/atp_poly.sv
`timescale 1ns / 1ps
module atp_poly #(
   parameter int SIDE_W = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  atp_pkg::q_type      in_x,
   input  logic [SIDE_W-1:0]   in_side,
   output logic                out_valid,
   output atp_pkg::q_type      out_r,
   output logic [SIDE_W-1:0]   out_side
);
   import atp_pkg::*;

   localparam int NST = 6;

   logic              v_ff    [NST];
   logic [SIDE_W-1:0] side_ff [NST];
   q_type x_ff [3];
   q_type x2_ff [3];
   q_type t3_ff, t5_ff, t7_ff, c3_ff, c5_ff, c7_ff;
   q_type r4_ff, r5_ff, r6_ff;
   q_type x2_in, t3_in, t5_in, c3_in, t7_in, c5_in, r4_in, c7_in, r5_in, r6_in;

   // at most one multiply level per stage
   assign x2_in = qmul(in_x, in_x);
   assign t3_in = qmul(x_ff[0], x2_ff[0]);
   assign t5_in = qmul(t3_ff, x2_ff[1]);
   assign c3_in = qmul(t3_ff, C_THIRD);
   assign r4_in = x_ff[2] - c3_ff;
   assign t7_in = qmul(t5_ff, x2_ff[2]);
   assign c5_in = qmul(t5_ff, C_FIFTH);
   assign r5_in = r4_ff + c5_ff;
   assign c7_in = qmul(t7_ff, C_SEVENTH);
   assign r6_in = r5_ff - c7_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NST; s++) v_ff[s] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
         for (int s = 1; s < NST; s++) v_ff[s] <= v_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
         for (int s = 1; s < NST; s++) side_ff[s] <= side_ff[s-1];
         x_ff[0]  <= in_x;
         x_ff[1]  <= x_ff[0];
         x_ff[2]  <= x_ff[1];
         x2_ff[0] <= x2_in;
         x2_ff[1] <= x2_ff[0];
         x2_ff[2] <= x2_ff[1];
         t3_ff    <= t3_in;
         t5_ff    <= t5_in;
         c3_ff    <= c3_in;
         r4_ff    <= r4_in;
         t7_ff    <= t7_in;
         c5_ff    <= c5_in;
         r5_ff    <= r5_in;
         c7_ff    <= c7_in;
         r6_ff    <= r6_in;
      end
   end

   assign out_valid = v_ff[NST-1];
   assign out_r     = r6_ff;
   assign out_side  = side_ff[NST-1];

endmodule

>>> hdl/q16_arctangent_piecewise_top.sv
`timescale 1ns / 1ps
// q16.16 arctangent, fully pipelined
// req channel: req_tdata[31:0] carries value_in (signed q16.16)
// rsp channel: rsp_tdata[17:0] carries angle_out (signed q2.16 radians)
// throughput: one item per cycle while the receiver does not stall; each of the 24 stages holds one item
// the path is: input register, reciprocal pipeline (7 stages) for inputs
// above one, range split, reciprocal pipeline (7 stages) for the reduced
// denominator, reduction multiply, polynomial pipeline (6 stages), output
// register
// reset clears every stage valid bit; rsp_tvalid is low from the first
// clock edge with reset high
// when the receiver stalls with a result waiting, the whole pipeline holds
// and req_tready goes low in the same cycle; nothing is lost or repeated
module q16_arctangent_piecewise_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [17:0] angle_out, [23:18] zero
);
   import atp_pkg::*;

   logic en;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // input stage: sign strip and range flags
   logic  a_v_ff, a_neg_ff, a_zero_ff, a_big_ff;
   q_type a_mag_ff;
   q_type x_in, mag_in;
   logic  neg_in;

   always_comb begin
      x_in   = q_type'(req_tdata);
      neg_in = x_in[31];
      if (x_in == q_type'(32'h8000_0000)) mag_in = q_type'(32'h7fff_ffff);
      else if (neg_in)                    mag_in = -x_in;
      else                                mag_in = x_in;
   end

   always_ff @(posedge clock) begin
      if (reset)   a_v_ff <= 1'b0;
      else if (en) a_v_ff <= req_tvalid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_neg_ff  <= neg_in;
         a_zero_ff <= (x_in == 0);
         a_big_ff  <= (mag_in > Q_ONE);
         a_mag_ff  <= mag_in;
      end
   end

   // first reciprocal, used only above one
   localparam int S1_W = 3 + 32;
   logic              r1_v;
   q_type             r1_val;
   logic [S1_W-1:0]   r1_side;

   atp_recip #(.SIDE_W(S1_W)) u_recip_big (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (a_v_ff),
      .in_value  (a_mag_ff),
      .in_side   ({a_neg_ff, a_zero_ff, a_big_ff, a_mag_ff}),
      .out_valid (r1_v),
      .out_value (r1_val),
      .out_side  (r1_side)
   );

   // range split in [0,1]: direct or shifted by one half
   logic  b_v_ff, b_neg_ff, b_zero_ff, b_big_ff, b_lo_ff;
   q_type b_a_ff, b_num_ff, b_den_ff;
   q_type a_sel, a_rnd;

   always_comb begin
      a_sel = r1_side[32] ? r1_val : q_type'(r1_side[31:0]);
      a_rnd = a_sel + q_type'({31'd0, a_sel[31]});
   end

   always_ff @(posedge clock) begin
      if (reset)   b_v_ff <= 1'b0;
      else if (en) b_v_ff <= r1_v;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_neg_ff  <= r1_side[34];
         b_zero_ff <= r1_side[33];
         b_big_ff  <= r1_side[32];
         b_lo_ff   <= (a_sel <= Q_HALF);
         b_a_ff    <= a_sel;
         b_num_ff  <= a_sel - Q_HALF;
         b_den_ff  <= Q_ONE + (a_rnd >>> 1);
      end
   end

   // second reciprocal on 1 + a/2
   localparam int S2_W = 4 + 64;
   logic            r2_v;
   q_type           r2_val;
   logic [S2_W-1:0] r2_side;

   atp_recip #(.SIDE_W(S2_W)) u_recip_den (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (b_v_ff),
      .in_value  (b_den_ff),
      .in_side   ({b_neg_ff, b_zero_ff, b_big_ff, b_lo_ff, b_a_ff, b_num_ff}),
      .out_valid (r2_v),
      .out_value (r2_val),
      .out_side  (r2_side)
   );

   // reduced argument
   logic  c_v_ff;
   logic  [3:0] c_flags_ff;
   q_type c_x_ff, red_in;

   assign red_in = qmul(q_type'(r2_side[31:0]), r2_val);

   always_ff @(posedge clock) begin
      if (reset)   c_v_ff <= 1'b0;
      else if (en) c_v_ff <= r2_v;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_flags_ff <= r2_side[67:64];
         c_x_ff     <= r2_side[64] ? q_type'(r2_side[63:32]) : red_in;
      end
   end

   // odd polynomial
   logic       p_v;
   q_type      p_r;
   logic [3:0] p_flags;

   atp_poly #(.SIDE_W(4)) u_poly (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (c_v_ff),
      .in_x      (c_x_ff),
      .in_side   (c_flags_ff),
      .out_valid (p_v),
      .out_r     (p_r),
      .out_side  (p_flags)
   );

   // offset, fold back above one, restore sign
   logic        o_v_ff;
   logic [17:0] o_angle_ff;
   q_type       u_val, f_val, s_val;

   always_comb begin
      u_val = p_flags[0] ? p_r : Q_ATAN_HALF + p_r;
      f_val = p_flags[1] ? Q_PI_HALF - u_val : u_val;
      s_val = p_flags[3] ? -f_val : f_val;
      if (p_flags[2]) s_val = '0;
   end

   always_ff @(posedge clock) begin
      if (reset)   o_v_ff <= 1'b0;
      else if (en) o_v_ff <= p_v;
   end

   always_ff @(posedge clock) begin
      if (en) o_angle_ff <= s_val[17:0];
   end

   assign rsp_tvalid = o_v_ff;
   assign rsp_tdata  = {6'd0, o_angle_ff};

endmodule

>>> hdl/atp_checker.sv
`timescale 1ns / 1ps
module atp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   // no result right after reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // input side moves exactly when the output side can
   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("req_tready does not follow output stall");

   // padding above the 18-bit result field is always zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[23:18] == 6'd0))
      else $error("rsp_tdata padding not zero");

   // stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

endmodule

bind q16_arctangent_piecewise_top atp_checker u_atp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
